// ===== rtl/pwpm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pwpm_pkg;

  // Field widths.
  localparam int COEF_W     = 32;
  localparam int COORD_W    = 10;
  localparam int PIX_W      = 24;
  localparam int NUM_COEFS  = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int COEF_SEL_W = 3;

  // Coordinate times coefficient, then a three-term sum, then its magnitude.
  localparam int PROD_W = COEF_W + COORD_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int MAG_W  = SUM_W - 1;

  // Width that holds any image dimension in the allowed range.
  localparam int DIM_W = 14;

  localparam int DEF_SRC_WIDTH  = 1024;
  localparam int DEF_SRC_HEIGHT = 1024;
  localparam int DEF_DST_WIDTH  = 1024;
  localparam int DEF_DST_HEIGHT = 1024;

  // Register indexes.
  localparam int COEF_00_IDX = 0;
  localparam int COEF_11_IDX = 4;

  // One in Q16.16.
  localparam logic signed [SUM_W-1:0] Q_ONE = SUM_W'(65536);
  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(65536);

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [NUM_COEFS-1:0] coef_vec_t;

  // Data that rides along with each beat.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             src_ok;
  } side_t;

  // Status from the divider for the final check.
  typedef struct packed {
    logic negx;
    logic negy;
    logic wz;
    logic ovx;
    logic ovy;
  } div_flags_t;

  function automatic coef_t coef_reset(int unsigned idx);
    coef_t val;
    val = '0;
    if (idx == COEF_00_IDX || idx == COEF_11_IDX) begin
      val = COEF_ONE;
    end
    return val;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/perspective_warp_pixel_mapper_unit.sv =====
// Channel   Ports                                            Handshake
// input     in_src_col, in_src_row, in_src_pixel             start & !busy
// result    out_dst_col/row/pixel, out_write_enable          out_strobe, one cycle
// config    cfg_index, cfg_data                              cfg_valid & cfg_ready
//
// One pixel is taken every cycle; busy stays low. Each result passes
// through the MAC stages, the divider's sign and range stages, one
// divider stage per quotient bit and the result register.
// Reset clears the coefficients to identity and empties the pipeline.
// The receiver cannot stall, so nothing in the pipeline ever waits.
`timescale 1ns / 1ps
`default_nettype none
module perspective_warp_pixel_mapper_unit import pwpm_pkg::*; #(
  parameter int SRC_WIDTH  = DEF_SRC_WIDTH,
  parameter int SRC_HEIGHT = DEF_SRC_HEIGHT,
  parameter int DST_WIDTH  = DEF_DST_WIDTH,
  parameter int DST_HEIGHT = DEF_DST_HEIGHT
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [COORD_W-1:0]    in_src_col,
  input  wire logic [COORD_W-1:0]    in_src_row,
  input  wire logic [PIX_W-1:0]      in_src_pixel,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [COEF_W-1:0]     cfg_data,
  output logic                       out_strobe,
  output logic [COORD_W-1:0]         out_dst_col,
  output logic [COORD_W-1:0]         out_dst_row,
  output logic [PIX_W-1:0]           out_dst_pixel,
  output logic                       out_write_enable
);

  localparam int DST_MAX = (DST_WIDTH > DST_HEIGHT) ? DST_WIDTH : DST_HEIGHT;
  localparam int QW      = $clog2(DST_MAX);

  coef_vec_t               coef_r;
  side_t                   in_side;
  logic                    mac_valid;
  logic signed [SUM_W-1:0] mac_x;
  logic signed [SUM_W-1:0] mac_y;
  logic signed [SUM_W-1:0] mac_w;
  side_t                   mac_side;
  logic                    div_valid;
  logic [QW-1:0]           div_qx;
  logic [QW-1:0]           div_qy;
  div_flags_t              div_flags;
  side_t                   div_side;
  logic                    we;
  logic [QW+COORD_W-1:0]   qx_ext;
  logic [QW+COORD_W-1:0]   qy_ext;

  logic                    strobe_r;
  logic [COORD_W-1:0]      col_r;
  logic [COORD_W-1:0]      row_r;
  logic [PIX_W-1:0]        pix_r;
  logic                    we_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Coefficient registers; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEFS; i++) begin
        coef_r[i] <= coef_reset(i);
      end
    end else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_COEFS))) begin
      coef_r[cfg_index[COEF_SEL_W-1:0]] <= cfg_data;
    end
  end

  // Source bounds are checked on entry and carried along.
  assign in_side.pixel  = in_src_pixel;
  assign in_side.src_ok = (DIM_W'(in_src_col) < DIM_W'(SRC_WIDTH)) &&
                          (DIM_W'(in_src_row) < DIM_W'(SRC_HEIGHT));

  pwpm_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start & ~busy),
    .in_col    (in_src_col),
    .in_row    (in_src_row),
    .coef      (coef_r),
    .in_side   (in_side),
    .out_valid (mac_valid),
    .out_x     (mac_x),
    .out_y     (mac_y),
    .out_w     (mac_w),
    .out_side  (mac_side)
  );

  pwpm_div #(.QW(QW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mac_valid),
    .in_x      (mac_x),
    .in_y      (mac_y),
    .in_w      (mac_w),
    .in_side   (mac_side),
    .out_valid (div_valid),
    .out_qx    (div_qx),
    .out_qy    (div_qy),
    .out_flags (div_flags),
    .out_side  (div_side)
  );

  // A negative nonzero quotient, an overflow or a zero divisor is off-image.
  assign we = div_side.src_ok && !div_flags.wz && !div_flags.ovx && !div_flags.ovy &&
              !(div_flags.negx && (div_qx != '0)) &&
              !(div_flags.negy && (div_qy != '0)) &&
              ((QW+1)'(div_qx) < (QW+1)'(DST_WIDTH)) &&
              ((QW+1)'(div_qy) < (QW+1)'(DST_HEIGHT));

  assign qx_ext = {COORD_W'(0), div_qx};
  assign qy_ext = {COORD_W'(0), div_qy};

  // Result register.
  always_ff @(posedge clk) begin
    col_r <= we ? qx_ext[COORD_W-1:0] : '0;
    row_r <= we ? qy_ext[COORD_W-1:0] : '0;
    pix_r <= div_side.pixel;
    if (!rst_n) begin
      strobe_r <= 1'b0;
      we_r     <= 1'b0;
    end else begin
      strobe_r <= div_valid;
      we_r     <= div_valid && we;
    end
  end

  assign out_strobe       = strobe_r;
  assign out_dst_col      = col_r;
  assign out_dst_row      = row_r;
  assign out_dst_pixel    = pix_r;
  assign out_write_enable = we_r;

endmodule
`default_nettype wire

// ===== rtl/pwpm_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pwpm_mac import pwpm_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire logic [COORD_W-1:0]      in_col,
  input  wire logic [COORD_W-1:0]      in_row,
  input  wire coef_vec_t               coef,
  input  wire side_t                   in_side,
  output logic                         out_valid,
  output logic signed [SUM_W-1:0]      out_x,
  output logic signed [SUM_W-1:0]      out_y,
  output logic signed [SUM_W-1:0]      out_w,
  output side_t                        out_side
);

  logic signed [COORD_W:0] col_s;
  logic signed [COORD_W:0] row_s;
  logic signed [PROD_W-1:0] prod_r [6];
  logic signed [PROD_W-1:0] k02_r;
  logic signed [PROD_W-1:0] k12_r;
  logic                     v1_r;
  side_t                    side1_r;
  logic                     v2_r;
  logic signed [SUM_W-1:0]  x_r;
  logic signed [SUM_W-1:0]  y_r;
  logic signed [SUM_W-1:0]  w_r;
  side_t                    side2_r;

  assign col_s = signed'({1'b0, in_col});
  assign row_s = signed'({1'b0, in_row});

  // Stage one: the six products and the two translations.
  always_ff @(posedge clk) begin
    prod_r[0] <= PROD_W'(col_s) * PROD_W'(coef[0]);
    prod_r[1] <= PROD_W'(row_s) * PROD_W'(coef[1]);
    prod_r[2] <= PROD_W'(col_s) * PROD_W'(coef[3]);
    prod_r[3] <= PROD_W'(row_s) * PROD_W'(coef[4]);
    prod_r[4] <= PROD_W'(col_s) * PROD_W'(coef[6]);
    prod_r[5] <= PROD_W'(row_s) * PROD_W'(coef[7]);
    k02_r     <= PROD_W'(coef[2]);
    k12_r     <= PROD_W'(coef[5]);
    side1_r   <= in_side;
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
  end

  // Stage two: the three homogeneous coordinates.
  always_ff @(posedge clk) begin
    x_r     <= SUM_W'(prod_r[0]) + SUM_W'(prod_r[1]) + SUM_W'(k02_r);
    y_r     <= SUM_W'(prod_r[2]) + SUM_W'(prod_r[3]) + SUM_W'(k12_r);
    w_r     <= SUM_W'(prod_r[4]) + SUM_W'(prod_r[5]) + Q_ONE;
    side2_r <= side1_r;
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  assign out_valid = v2_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_w     = w_r;
  assign out_side  = side2_r;

endmodule
`default_nettype wire

// ===== rtl/pwpm_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pwpm_div import pwpm_pkg::*; #(
  parameter int QW = 10
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire logic signed [SUM_W-1:0] in_x,
  input  wire logic signed [SUM_W-1:0] in_y,
  input  wire logic signed [SUM_W-1:0] in_w,
  input  wire side_t                   in_side,
  output logic                         out_valid,
  output logic [QW-1:0]                out_qx,
  output logic [QW-1:0]                out_qy,
  output div_flags_t                   out_flags,
  output side_t                        out_side
);

  localparam int RW = MAG_W + QW;

  typedef struct packed {
    logic [MAG_W-1:0] aw;
    div_flags_t       flags;
    side_t            side;
  } meta_t;

  logic [SUM_W-1:0] absx;
  logic [SUM_W-1:0] absy;
  logic [SUM_W-1:0] absw;

  logic             va_r;
  logic [MAG_W-1:0] ax_r;
  logic [MAG_W-1:0] ay_r;
  logic [MAG_W-1:0] aw_r;
  logic             nx_r;
  logic             ny_r;
  logic             wz_r;
  side_t            sidea_r;

  logic [QW:0]   v_r;
  logic [RW-1:0] rx_r [QW+1];
  logic [RW-1:0] ry_r [QW+1];
  logic [QW-1:0] qx_r [QW+1];
  logic [QW-1:0] qy_r [QW+1];
  meta_t         meta_r [QW+1];

  // Signs and magnitudes.
  assign absx = in_x[SUM_W-1] ? SUM_W'(-in_x) : SUM_W'(in_x);
  assign absy = in_y[SUM_W-1] ? SUM_W'(-in_y) : SUM_W'(in_y);
  assign absw = in_w[SUM_W-1] ? SUM_W'(-in_w) : SUM_W'(in_w);

  always_ff @(posedge clk) begin
    ax_r    <= absx[MAG_W-1:0];
    ay_r    <= absy[MAG_W-1:0];
    aw_r    <= absw[MAG_W-1:0];
    nx_r    <= in_x[SUM_W-1] ^ in_w[SUM_W-1];
    ny_r    <= in_y[SUM_W-1] ^ in_w[SUM_W-1];
    wz_r    <= (in_w == '0);
    sidea_r <= in_side;
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= in_valid;
    end
  end

  // A quotient of 2**QW or more is off any destination; flag it and divide
  // only what fits.
  always_ff @(posedge clk) begin
    rx_r[0]             <= RW'(ax_r);
    ry_r[0]             <= RW'(ay_r);
    qx_r[0]             <= '0;
    qy_r[0]             <= '0;
    meta_r[0].aw        <= aw_r;
    meta_r[0].flags.negx <= nx_r;
    meta_r[0].flags.negy <= ny_r;
    meta_r[0].flags.wz  <= wz_r;
    meta_r[0].flags.ovx <= (RW'(ax_r) >= {aw_r, QW'(0)});
    meta_r[0].flags.ovy <= (RW'(ay_r) >= {aw_r, QW'(0)});
    meta_r[0].side      <= sidea_r;
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= va_r;
    end
  end

  // One restoring quotient bit per stage, most significant first.
  for (genvar i = 0; i < QW; i++) begin : g_bit
    localparam int K = QW - 1 - i;
    logic [RW-1:0] dsh;
    logic          bx;
    logic          by;
    logic [QW-1:0] qx_nxt;
    logic [QW-1:0] qy_nxt;

    assign dsh = RW'(meta_r[i].aw) << K;
    assign bx  = (rx_r[i] >= dsh);
    assign by  = (ry_r[i] >= dsh);

    always_comb begin
      qx_nxt    = qx_r[i];
      qy_nxt    = qy_r[i];
      qx_nxt[K] = bx;
      qy_nxt[K] = by;
    end

    always_ff @(posedge clk) begin
      rx_r[i+1]   <= bx ? (rx_r[i] - dsh) : rx_r[i];
      ry_r[i+1]   <= by ? (ry_r[i] - dsh) : ry_r[i];
      qx_r[i+1]   <= qx_nxt;
      qy_r[i+1]   <= qy_nxt;
      meta_r[i+1] <= meta_r[i];
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else begin
        v_r[i+1] <= v_r[i];
      end
    end
  end

  assign out_valid = v_r[QW];
  assign out_qx    = qx_r[QW];
  assign out_qy    = qy_r[QW];
  assign out_flags = meta_r[QW].flags;
  assign out_side  = meta_r[QW].side;

endmodule
`default_nettype wire

// ===== rtl/pwpm_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pwpm_chk import pwpm_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               busy,
  input wire logic               out_strobe,
  input wire logic               out_write_enable,
  input wire logic [COORD_W-1:0] out_dst_col,
  input wire logic [COORD_W-1:0] out_dst_row
);

  // Write enable only comes with a result beat.
  a_we_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_write_enable |-> out_strobe)
    else $error("write enable without strobe");

  // A dropped pixel carries zero coordinates.
  a_zero_coord: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_write_enable) |-> (out_dst_col == '0 && out_dst_row == '0))
    else $error("nonzero coordinates on a dropped pixel");

  // The pipeline is empty in the first cycle after reset is released.
  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_strobe)
    else $error("result beat right after reset");

  // The block takes a pixel every cycle.
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised");

endmodule

bind perspective_warp_pixel_mapper_unit pwpm_chk u_pwpm_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .busy             (busy),
  .out_strobe       (out_strobe),
  .out_write_enable (out_write_enable),
  .out_dst_col      (out_dst_col),
  .out_dst_row      (out_dst_row)
);
`default_nettype wire
